FILE: sv/spi_flash_command_shifter_macros.svh
// Assertion macros for the SPI flash command shifter.
`ifndef SPI_FLASH_COMMAND_SHIFTER_MACROS_SVH
`define SPI_FLASH_COMMAND_SHIFTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfcs assertion failed");

// Next-cycle implication, disabled during reset.
`define SFCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfcs assertion failed");

`endif

FILE: sv/sfcs_pkg.sv
// Types and constants shared by the SPI flash command shifter modules.
`default_nettype none
package sfcs_pkg;
   localparam int unsigned SHIFT_W = 32;
   localparam int unsigned CNT_W   = 6;

   localparam logic [2:0] KIND_CMD   = 3'd0;
   localparam logic [2:0] KIND_ADDR  = 3'd1;
   localparam logic [2:0] KIND_WRITE = 3'd2;
   localparam logic [2:0] KIND_READ  = 3'd3;
   localparam logic [2:0] KIND_END   = 3'd4;

   localparam logic [1:0] OP_SHIFT = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic               pre_cs;
      logic               cs_n;
      logic [CNT_W-1:0]   nbits;
      logic [SHIFT_W-1:0] word;
      logic [7:0]         rbyte;
   } desc_type;
endpackage
`default_nettype wire

FILE: sv/sfcs_front.sv
// Front end: accepts transactions, tracks chip select and builds shift descriptors.
`default_nettype none
module sfcs_front
   import sfcs_pkg::*;
#(
   parameter int unsigned ADDRESS_BITS = 24
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire logic [2:0]   kind,
   input  wire logic [23:0]  value,
   input  wire logic [7:0]   miso_bits,
   output logic              desc_valid,
   output desc_type          desc
);
   localparam int unsigned ALIGN = SHIFT_W - ADDRESS_BITS;

   logic               select_ff;
   logic               select_in;
   logic [SHIFT_W-1:0] addr_word;
   logic [SHIFT_W-1:0] byte_word;

   assign addr_word = {{(SHIFT_W-24){1'b0}}, value} << ALIGN;
   assign byte_word = {value[7:0], {(SHIFT_W-8){1'b0}}};

   always_comb begin
      select_in   = select_ff;
      desc_valid  = 1'b0;
      desc.op     = OP_SHIFT;
      desc.pre_cs = 1'b0;
      desc.cs_n   = ~select_ff;
      desc.nbits  = CNT_W'(8);
      desc.word   = byte_word;
      desc.rbyte  = miso_bits;
      case (kind)
         KIND_CMD: begin
            desc_valid  = accept;
            desc.pre_cs = ~select_ff;
            desc.cs_n   = 1'b0;
            select_in   = select_ff | accept;
         end
         KIND_ADDR: begin
            desc_valid = accept;
            desc.nbits = CNT_W'(ADDRESS_BITS);
            desc.word  = addr_word;
         end
         KIND_WRITE: begin
            desc_valid = accept;
         end
         KIND_READ: begin
            desc_valid = accept;
            desc.op    = OP_READ;
         end
         KIND_END: begin
            desc_valid = accept & select_ff;
            desc.op    = OP_END;
            desc.cs_n  = 1'b1;
            select_in  = select_ff & ~accept;
         end
         default: begin
            desc_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         select_ff <= 1'b0;
      end else begin
         select_ff <= select_in;
      end
   end
endmodule
`default_nettype wire

FILE: sv/sfcs_queue.sv
// Two-entry descriptor queue between the front end and the shift engine.
`default_nettype none
module sfcs_queue
   import sfcs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire desc_type push_desc,
   output logic          full,
   input  wire logic     pop,
   output logic          valid,
   output desc_type      pop_desc
);
   desc_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full     = count_ff == 2'd2;
   assign valid    = count_ff != 2'd0;
   assign pop_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end
endmodule
`default_nettype wire

FILE: sv/sfcs_back.sv
// Shift engine: runs descriptors as SCK pulses and chip select changes.
`default_nettype none
module sfcs_back
   import sfcs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_valid,
   input  wire desc_type q_desc,
   output logic          q_pop,
   input  wire logic     out_take,
   output logic          out_empty,
   output logic          out_cs_n,
   output logic          out_pulse,
   output logic          out_mosi,
   output logic [7:0]    out_read_byte,
   output logic          out_last
);
   logic               busy_ff, busy_in;
   logic               half_ff, half_in;
   logic               mosi_level_ff, mosi_level_in;
   logic               out_valid_ff, out_valid_in;
   logic [1:0]         op_ff, op_in;
   logic               pre_ff, pre_in;
   logic               cs_n_ff, cs_n_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SHIFT_W-1:0] word_ff, word_in;
   logic [7:0]         rbyte_ff, rbyte_in;
   logic               o_cs_n_ff, o_cs_n_in;
   logic               o_pulse_ff, o_pulse_in;
   logic               o_mosi_ff, o_mosi_in;
   logic [7:0]         o_rbyte_ff, o_rbyte_in;
   logic               o_last_ff, o_last_in;
   logic               emit_ok;
   logic               final_bit;

   assign emit_ok   = !out_valid_ff || out_take;
   assign final_bit = cnt_ff == CNT_W'(1);
   assign q_pop     = !busy_ff && q_valid;

   assign out_empty     = !out_valid_ff;
   assign out_cs_n      = o_cs_n_ff;
   assign out_pulse     = o_pulse_ff;
   assign out_mosi      = o_mosi_ff;
   assign out_read_byte = o_rbyte_ff;
   assign out_last      = o_last_ff;

   always_comb begin
      busy_in       = busy_ff;
      half_in       = half_ff;
      mosi_level_in = mosi_level_ff;
      out_valid_in  = out_valid_ff && !out_take;
      op_in         = op_ff;
      pre_in        = pre_ff;
      cs_n_in       = cs_n_ff;
      cnt_in        = cnt_ff;
      word_in       = word_ff;
      rbyte_in      = rbyte_ff;
      o_cs_n_in     = o_cs_n_ff;
      o_pulse_in    = o_pulse_ff;
      o_mosi_in     = o_mosi_ff;
      o_rbyte_in    = o_rbyte_ff;
      o_last_in     = o_last_ff;
      if (q_pop) begin
         busy_in  = 1'b1;
         half_in  = 1'b0;
         op_in    = q_desc.op;
         pre_in   = q_desc.pre_cs;
         cs_n_in  = q_desc.cs_n;
         cnt_in   = q_desc.nbits;
         word_in  = q_desc.word;
         rbyte_in = q_desc.rbyte;
      end else if (busy_ff && emit_ok) begin
         half_in = ~half_ff;
         if (half_ff) begin
            out_valid_in = 1'b1;
            o_mosi_in    = mosi_level_ff;
            o_rbyte_in   = 8'd0;
            if (pre_ff) begin
               pre_in     = 1'b0;
               o_cs_n_in  = 1'b0;
               o_pulse_in = 1'b0;
               o_last_in  = 1'b0;
            end else begin
               case (op_ff)
                  OP_SHIFT: begin
                     o_cs_n_in     = cs_n_ff;
                     o_pulse_in    = 1'b1;
                     o_mosi_in     = word_ff[SHIFT_W-1];
                     mosi_level_in = word_ff[SHIFT_W-1];
                     o_last_in     = final_bit;
                     word_in       = {word_ff[SHIFT_W-2:0], 1'b0};
                     cnt_in        = cnt_ff - CNT_W'(1);
                     busy_in       = !final_bit;
                  end
                  OP_READ: begin
                     o_cs_n_in  = cs_n_ff;
                     o_pulse_in = 1'b1;
                     o_last_in  = final_bit;
                     o_rbyte_in = final_bit ? rbyte_ff : 8'd0;
                     cnt_in     = cnt_ff - CNT_W'(1);
                     busy_in    = !final_bit;
                  end
                  default: begin
                     o_cs_n_in  = 1'b1;
                     o_pulse_in = 1'b0;
                     o_last_in  = 1'b1;
                     busy_in    = 1'b0;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      pre_ff     <= pre_in;
      cs_n_ff    <= cs_n_in;
      cnt_ff     <= cnt_in;
      word_ff    <= word_in;
      rbyte_ff   <= rbyte_in;
      o_cs_n_ff  <= o_cs_n_in;
      o_pulse_ff <= o_pulse_in;
      o_mosi_ff  <= o_mosi_in;
      o_rbyte_ff <= o_rbyte_in;
      o_last_ff  <= o_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         half_ff       <= 1'b0;
         mosi_level_ff <= 1'b1;
         out_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         half_ff       <= half_in;
         mosi_level_ff <= mosi_level_in;
         out_valid_ff  <= out_valid_in;
      end
   end
endmodule
`default_nettype wire

FILE: sv/spi_flash_command_shifter.sv
// SPI mode 0 flash command shifter: front end, descriptor queue and shift engine.
// The shift engine loads one item at a time from the queue and produces its results in order;
// it stalls while the result slot is full, and a command that selects first emits a select result.
// The two-entry queue lets new transactions be taken while the engine shifts.
// Reset (synchronous): chip deselected, MOSI level high, queue and result slot empty.
`default_nettype none
`include "spi_flash_command_shifter_macros.svh"
module spi_flash_command_shifter
   import sfcs_pkg::*;
#(
   parameter int unsigned ADDRESS_BITS = 24
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_push,
   output logic              req_full,
   input  wire logic [2:0]   req_kind,
   input  wire logic [23:0]  req_value,
   input  wire logic [7:0]   req_miso_bits,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output logic              rsp_cs_n,
   output logic              rsp_pulse,
   output logic              rsp_mosi,
   output logic [7:0]        rsp_read_byte,
   output logic              rsp_last
);
   logic     accept;
   logic     f_valid;
   desc_type f_desc;
   logic     q_full;
   logic     q_valid;
   logic     q_pop;
   desc_type q_desc;
   logic     take;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign take     = rsp_pop && !rsp_empty;

   sfcs_front #(
      .ADDRESS_BITS(ADDRESS_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_kind),
      .value     (req_value),
      .miso_bits (req_miso_bits),
      .desc_valid(f_valid),
      .desc      (f_desc)
   );

   sfcs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_valid),
      .push_desc(f_desc),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_desc (q_desc)
   );

   sfcs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_desc       (q_desc),
      .q_pop        (q_pop),
      .out_take     (take),
      .out_empty    (rsp_empty),
      .out_cs_n     (rsp_cs_n),
      .out_pulse    (rsp_pulse),
      .out_mosi     (rsp_mosi),
      .out_read_byte(rsp_read_byte),
      .out_last     (rsp_last)
   );

   `SFCS_ASSERT_NOW(a_select_result, clock, reset, !rsp_empty && !rsp_pulse, rsp_cs_n == rsp_last)
   `SFCS_ASSERT_NOW(a_byte_on_last, clock, reset, !rsp_empty && rsp_read_byte != 8'd0, rsp_last)
   `SFCS_ASSERT_NOW(a_no_push_full, clock, reset, f_valid, !q_full)
   `SFCS_ASSERT_NEXT(a_hold_when_stalled, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty)
endmodule
`default_nettype wire

FILE: verif/spi_flash_command_shifter_checker.sv
// Checker for the SPI flash command shifter: predicts pin activity per transaction and compares.
`timescale 1ns / 1ps
module spi_flash_command_shifter_checker
   import sfcs_pkg::*;
#(
   parameter int unsigned ADDRESS_BITS = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic        req_full,
   input  wire logic [2:0]  req_kind,
   input  wire logic [23:0] req_value,
   input  wire logic [7:0]  req_miso_bits,
   input  wire logic        rsp_empty,
   input  wire logic        rsp_pop,
   input  wire logic        rsp_cs_n,
   input  wire logic        rsp_pulse,
   input  wire logic        rsp_mosi,
   input  wire logic [7:0]  rsp_read_byte,
   input  wire logic        rsp_last,
   output int unsigned      error_count,
   output int unsigned      pending_results
);
   typedef struct packed {
      logic       cs_n;
      logic       pulse;
      logic       mosi;
      logic [7:0] read_byte;
      logic       last;
   } pin_state_type;

   pin_state_type expected_pins[$];
   pin_state_type oldest_state;
   pin_state_type seen_state;
   logic          flash_select;
   logic          mosi_hold;

   function automatic void push_pins(input logic cs_n, input logic pulse, input logic mosi,
                                     input logic [7:0] read_byte, input logic last);
      pin_state_type entry;
      entry.cs_n      = cs_n;
      entry.pulse     = pulse;
      entry.mosi      = mosi;
      entry.read_byte = read_byte;
      entry.last      = last;
      expected_pins.push_back(entry);
   endfunction

   function automatic void shift_bits_out(input logic [31:0] word, input int unsigned nbits);
      int unsigned i;
      for (i = 0; i < nbits; i++) begin
         mosi_hold = word[nbits - 1 - i];
         push_pins(~flash_select, 1'b1, mosi_hold, 8'h00, i + 1 == nbits);
      end
   endfunction

   function automatic void predict_transaction(input logic [2:0] kind, input logic [23:0] value,
                                               input logic [7:0] miso);
      logic [7:0]  gathered;
      int unsigned i;
      gathered = 8'h00;
      case (kind)
         KIND_CMD: begin
            if (!flash_select) begin
               flash_select = 1'b1;
               push_pins(1'b0, 1'b0, mosi_hold, 8'h00, 1'b0);
            end
            shift_bits_out({24'h0, value[7:0]}, 8);
         end
         KIND_ADDR: shift_bits_out({8'h0, value}, ADDRESS_BITS);
         KIND_WRITE: shift_bits_out({24'h0, value[7:0]}, 8);
         KIND_READ: begin
            for (i = 0; i < 8; i++) begin
               gathered = {gathered[6:0], miso[7 - i]};
               push_pins(~flash_select, 1'b1, mosi_hold, (i == 7) ? gathered : 8'h00, i == 7);
            end
         end
         KIND_END: begin
            if (flash_select) begin
               flash_select = 1'b0;
               push_pins(1'b1, 1'b0, mosi_hold, 8'h00, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic int unsigned field_mismatch(input string field, input logic [7:0] want,
                                                  input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_pins.delete();
         flash_select = 1'b0;
         mosi_hold    = 1'b1;
         error_count  = 0;
      end else begin
         if (req_push && !req_full) begin
            predict_transaction(req_kind, req_value, req_miso_bits);
         end
         if (rsp_pop && !rsp_empty) begin
            seen_state = {rsp_cs_n, rsp_pulse, rsp_mosi, rsp_read_byte, rsp_last};
            if (expected_pins.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %h", $time, seen_state);
               error_count++;
            end else begin
               oldest_state = expected_pins.pop_front();
               if (field_mismatch("cs_n", 8'(oldest_state.cs_n), 8'(seen_state.cs_n))
                   + field_mismatch("pulse", 8'(oldest_state.pulse), 8'(seen_state.pulse))
                   + field_mismatch("mosi", 8'(oldest_state.mosi), 8'(seen_state.mosi))
                   + field_mismatch("read_byte", oldest_state.read_byte, seen_state.read_byte)
                   + field_mismatch("last", 8'(oldest_state.last), 8'(seen_state.last))
                   != 0) begin
                  error_count++;
               end
            end
         end
      end
      pending_results = expected_pins.size();
   end
endmodule

FILE: verif/tb_spi_flash_command_shifter.sv
// Testbench top for the SPI flash command shifter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_spi_flash_command_shifter;
   import sfcs_pkg::*;

   localparam int unsigned RANDOM_ITEMS   = 130;
   localparam int unsigned IDLE_PERCENT   = 18;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 20;
   localparam int unsigned QUIET_FIRST    = 40;
   localparam int unsigned QUIET_LAST     = 70;
   localparam int unsigned PAUSE_AT       = 65;
   localparam logic [2:0]  KIND_SPARE_LO  = KIND_END + 3'd1;
   localparam logic [2:0]  KIND_SPARE_HI  = 3'd7;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_push      = 1'b0;
   logic [2:0]  req_kind      = KIND_CMD;
   logic [23:0] req_value     = '0;
   logic [7:0]  req_miso_bits = '0;
   logic        rsp_pop       = 1'b0;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_cs_n;
   logic        rsp_pulse;
   logic        rsp_mosi;
   logic [7:0]  rsp_read_byte;
   logic        rsp_last;

   int unsigned error_count;
   int unsigned pending_results;
   int unsigned items_sent   = 0;
   int unsigned quiet_cycles = 0;
   logic        idle_enable  = 1'b1;
   logic        paused       = 1'b0;

   spi_flash_command_shifter DUT (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_kind      (req_kind),
      .req_value     (req_value),
      .req_miso_bits (req_miso_bits),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_cs_n      (rsp_cs_n),
      .rsp_pulse     (rsp_pulse),
      .rsp_mosi      (rsp_mosi),
      .rsp_read_byte (rsp_read_byte),
      .rsp_last      (rsp_last)
   );

   spi_flash_command_shifter_checker shifter_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .req_miso_bits   (req_miso_bits),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_cs_n        (rsp_cs_n),
      .rsp_pulse       (rsp_pulse),
      .rsp_mosi        (rsp_mosi),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_last        (rsp_last),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_pop <= !(idle_enable && $urandom_range(0, 99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("tb_spi_flash_command_shifter: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [2:0] kind, input logic [23:0] value,
                            input logic [7:0] miso);
      @(negedge clock);
      while (idle_enable && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push      <= 1'b1;
      req_kind      <= kind;
      req_value     <= value;
      req_miso_bits <= miso;
      do @(posedge clock); while (req_full);
      if (kind <= KIND_END) items_sent++;
   endtask

   task automatic random_transaction();
      int unsigned data_items;
      if ($urandom_range(0, 99) < 15) begin
         send_item(3'($urandom_range(KIND_CMD, KIND_SPARE_HI)), 24'($urandom), 8'($urandom));
         return;
      end
      send_item(KIND_CMD, 24'($urandom), 8'($urandom));
      if ($urandom_range(0, 99) < 70) send_item(KIND_ADDR, 24'($urandom), 8'($urandom));
      data_items = $urandom_range(0, 4);
      repeat (data_items) begin
         send_item(($urandom_range(0, 1) == 0) ? KIND_WRITE : KIND_READ, 24'($urandom),
                   8'($urandom));
      end
      if ($urandom_range(0, 99) < 90) send_item(KIND_END, 24'($urandom), 8'($urandom));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(KIND_END, 24'h000000, 8'h00);
      send_item(KIND_WRITE, 24'hFFFF00, 8'hFF);
      send_item(KIND_READ, 24'hFFFFFF, 8'hA5);
      send_item(KIND_ADDR, 24'hFFFFFF, 8'h00);
      send_item(KIND_SPARE_LO, 24'hFFFFFF, 8'hFF);
      send_item(KIND_SPARE_LO + 3'd1, 24'h123456, 8'h3C);
      send_item(KIND_SPARE_HI, 24'h000000, 8'h00);
      send_item(KIND_CMD, 24'hABCD9F, 8'h00);
      send_item(KIND_CMD, 24'h000003, 8'hFF);
      send_item(KIND_ADDR, 24'h000000, 8'h00);
      send_item(KIND_ADDR, 24'h800001, 8'h00);
      send_item(KIND_WRITE, 24'h0000FF, 8'h00);
      send_item(KIND_READ, 24'h000000, 8'h00);
      send_item(KIND_READ, 24'h000000, 8'hFF);
      send_item(KIND_WRITE, 24'hFFFF5A, 8'h00);
      send_item(KIND_READ, 24'h000000, 8'h5A);
      send_item(KIND_SPARE_HI, 24'hFFFFFF, 8'hFF);
      send_item(KIND_END, 24'hFFFFFF, 8'hFF);
      send_item(KIND_END, 24'h000000, 8'h00);
      send_item(KIND_CMD, 24'h000000, 8'h00);
      send_item(KIND_READ, 24'h000000, 8'h81);
      send_item(KIND_END, 24'h000000, 8'h00);

      while (items_sent < RANDOM_ITEMS) begin
         idle_enable = !(items_sent >= QUIET_FIRST && items_sent < QUIET_LAST);
         if (!paused && items_sent >= PAUSE_AT) begin
            @(negedge clock);
            req_push <= 1'b0;
            wait (pending_results == 0);
            paused = 1'b1;
         end
         random_transaction();
      end

      @(negedge clock);
      req_push <= 1'b0;
      wait (pending_results == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results == 0) begin
         $display("tb_spi_flash_command_shifter: clean");
      end else begin
         $display("tb_spi_flash_command_shifter: errors");
      end
      $finish;
   end
endmodule

FILE: files.f
+incdir+sv
sv/sfcs_pkg.sv
sv/sfcs_front.sv
sv/sfcs_queue.sv
sv/sfcs_back.sv
sv/spi_flash_command_shifter.sv
verif/spi_flash_command_shifter_checker.sv
verif/tb_spi_flash_command_shifter.sv
